[src/ktbl_pkg.sv]
// Shared types, codes and constants of the keyed token bucket limiter.
package ktbl_pkg;

  localparam int DEFAULT_SLOTS = 1024;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int LIMIT_W       = 10;
  localparam int RETRY_W       = 48;
  localparam int RATE_W        = 32;
  localparam int DIV_CNT_W     = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_CAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd2;

  localparam logic [31:0]        CAP_RESET   = 32'd655360;
  localparam logic [31:0]        RATE_RESET  = 32'd65536;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd768;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMITED = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] flow_key;
    logic [31:0] key_hash;
    logic [31:0] timestamp;
    logic [31:0] cost;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [RETRY_W-1:0]  retry_ticks;
    logic [LIMIT_W-1:0]  tracked_count;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] tokens;
    logic [31:0] last_time;
  } slot_row_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR_CUR,
    WR_CLR_NEW,
    WR_ROW_CUR,
    WR_INS,
    WR_ROW_NEW
  } wr_kind_t;

  typedef struct packed {
    logic     capture;
    logic     slot_ld_hash;
    logic     slot_clr;
    logic     slot_inc;
    logic     np_ld_hash;
    logic     np_clr;
    logic     np_inc;
    logic     rd_new;
    logic     cap_row;
    logic     mul;
    logic     refill;
    wr_kind_t wr_kind;
    logic     scan_clr;
    logic     scan_upd;
    logic     set_drop;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     live_clr;
    logic     live_inc;
    logic     live_ld_cnt;
    logic     bank_flip;
    logic     div_start;
    logic     res_set;
    status_t  res_status;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic cost_bad;
    logic rd_valid;
    logic rd_hit;
    logic slot_last;
    logic np_last;
    logic enough;
    logic has_room;
    logic skip;
    logic any;
    logic drop_en;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [5:0] {
    S_RST, S_INIT, S_IDLE, S_DEC, S_CLEAR,
    S_LK_RD, S_LK_CHK, S_F_MUL, S_F_REF, S_F_DEBIT, S_DIV,
    S_NF, S_INS,
    S_SC_RD, S_SC_CHK, S_SC_MUL, S_SC_REF, S_SC_UPD, S_SC_NXT, S_SC_END,
    S_CN,
    S_CP_RD, S_CP_CHK, S_CP_MUL, S_CP_REF, S_CP_EVAL, S_CP_PRD, S_CP_PCHK,
    S_CP_NXT, S_CP_FIN,
    S_ROOMCK, S_RELOOK, S_FIN
  } ctrl_state_t;

endpackage

[src/ktbl_div.sv]
// Restoring divider, one quotient bit per cycle, for the retry time.
module ktbl_div
  import ktbl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RETRY_W-1:0] dividend,
  input  logic [RATE_W-1:0]  divisor,
  output logic               busy,
  output logic [RETRY_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(RETRY_W - 1);

  logic [RATE_W-1:0]    rem_r;
  logic [RETRY_W-1:0]   quo_r;
  logic [RATE_W-1:0]    div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;
  logic                 ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, quo_r[RETRY_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo_r <= {quo_r[RETRY_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[src/ktbl_dp.sv]
// Datapath: bucket table memory, item and row registers, refill math, result register.
module ktbl_dp
  import ktbl_pkg::*;
#(
  parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int AW    = $clog2(TABLE_SLOTS);
  localparam int CW    = AW + 1;
  localparam int DEPTH = 2 * TABLE_SLOTS;
  localparam int CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [CW-1:0] LOAD_MAX = CW'(TABLE_SLOTS * 3 / 4);

  // Two banks: the current table and the target of a compaction
  slot_row_t slot_mem_r [DEPTH];
  slot_row_t rd_row_r;
  slot_row_t row_r;
  slot_row_t wr_row;
  logic [AW:0] rd_addr;
  logic [AW:0] wr_addr;
  logic        wr_en;

  in_item_t     item_r;
  logic [31:0]  cap_r;
  logic [31:0]  rate_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [AW-1:0] slot_r;
  logic [AW-1:0] np_r;
  logic [CW-1:0] live_r;
  logic [CW-1:0] cnt_r;
  logic          bank_r;

  logic          reclaim_r;
  logic          any_r;
  logic [31:0]   best_tok_r;
  logic [AW-1:0] best_slot_r;
  logic          drop_en_r;
  logic [AW-1:0] drop_slot_r;

  logic [63:0] prod_r;
  logic        gt_r;
  logic [63:0] prod_w;
  logic [31:0] delta;
  logic [64:0] sum;
  logic [31:0] refill_tok;
  logic        enough;
  logic        full;

  status_t     res_status_r;
  out_item_t   out_r;
  logic        out_valid_r;
  logic [31:0] live_ext;

  logic               div_busy;
  logic [RETRY_W-1:0] quotient;
  logic [RETRY_W-1:0] need;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      rate_r  <= RATE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURST_CAP:   cap_r   <= cfg_wdata;
        CFG_REFILL_RATE: rate_r  <= cfg_wdata;
        CFG_ENTRY_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Refill arithmetic
  assign delta      = item_r.timestamp - row_r.last_time;
  assign prod_w     = 64'(delta) * 64'(rate_r);
  assign sum        = 65'(prod_r) + 65'(row_r.tokens);
  assign refill_tok = (sum > 65'(cap_r)) ? cap_r : sum[31:0];
  assign enough     = row_r.tokens >= item_r.cost;
  assign full       = row_r.tokens >= cap_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_w;
      gt_r   <= item_r.timestamp > row_r.last_time;
    end
  end

  // Working row: loaded from memory, then refilled in place
  always_ff @(posedge clk) begin
    if (cmd.cap_row) begin
      row_r <= rd_row_r;
    end else if (cmd.refill && gt_r) begin
      row_r.tokens    <= refill_tok;
      row_r.last_time <= item_r.timestamp;
    end
  end

  // Probe and scan pointers
  always_ff @(posedge clk) begin
    if (cmd.slot_clr) begin
      slot_r <= '0;
    end else if (cmd.slot_ld_hash) begin
      slot_r <= item_r.key_hash[AW-1:0];
    end else if (cmd.slot_inc) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.np_clr) begin
      np_r <= '0;
    end else if (cmd.np_ld_hash) begin
      np_r <= row_r.hash[AW-1:0];
    end else if (cmd.np_inc) begin
      np_r <= np_r + 1'b1;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Key count and bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      bank_r <= 1'b0;
    end else begin
      if (cmd.live_clr) begin
        live_r <= '0;
      end else if (cmd.live_ld_cnt) begin
        live_r <= cnt_r;
      end else if (cmd.live_inc) begin
        live_r <= live_r + 1'b1;
      end
      if (cmd.bank_flip) begin
        bank_r <= ~bank_r;
      end
    end
  end

  // Reclaim flag and fullest bucket over a scan
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      reclaim_r <= 1'b0;
      any_r     <= 1'b0;
    end else if (cmd.scan_upd) begin
      if (full) begin
        reclaim_r <= 1'b1;
      end
      if (!any_r || row_r.tokens > best_tok_r) begin
        any_r       <= 1'b1;
        best_tok_r  <= row_r.tokens;
        best_slot_r <= slot_r;
      end
    end
    if (cmd.set_drop) begin
      drop_en_r   <= ~reclaim_r;
      drop_slot_r <= best_slot_r;
    end
  end

  // Memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {bank_r, slot_r};
    wr_row  = '0;
    unique case (cmd.wr_kind)
      WR_NONE: ;
      WR_CLR_CUR: begin
        wr_en = 1'b1;
      end
      WR_CLR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = {~bank_r, np_r};
      end
      WR_ROW_CUR: begin
        wr_en  = 1'b1;
        wr_row = row_r;
        if (enough) begin
          wr_row.tokens = row_r.tokens - item_r.cost;
        end
      end
      WR_INS: begin
        wr_en            = 1'b1;
        wr_row.valid     = 1'b1;
        wr_row.key       = item_r.flow_key;
        wr_row.hash      = item_r.key_hash;
        wr_row.tokens    = cap_r - item_r.cost;
        wr_row.last_time = item_r.timestamp;
      end
      WR_ROW_NEW: begin
        wr_en   = 1'b1;
        wr_addr = {~bank_r, np_r};
        wr_row  = row_r;
      end
      default: ;
    endcase
  end

  assign rd_addr = cmd.rd_new ? {~bank_r, np_r} : {bank_r, slot_r};

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_row;
    end
    rd_row_r <= slot_mem_r[rd_addr];
  end

  // Retry time divider
  assign need = {item_r.cost - row_r.tokens, 16'd0};

  ktbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (need),
    .divisor  (rate_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result register
  assign live_ext = 32'(live_r);

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_r.status        <= res_status_r;
      out_r.retry_ticks   <= (res_status_r == ST_LIMITED) ? quotient : '0;
      out_r.tracked_count <= live_ext[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status back to the controller
  always_comb begin
    sts.op_clear  = item_r.opcode == OP_CLEAR;
    sts.cost_bad  = (item_r.cost == '0) || (item_r.cost > cap_r);
    sts.rd_valid  = rd_row_r.valid;
    sts.rd_hit    = rd_row_r.valid && (rd_row_r.hash == item_r.key_hash) &&
                    (rd_row_r.key == item_r.flow_key);
    sts.slot_last = &slot_r;
    sts.np_last   = &np_r;
    sts.enough    = enough;
    sts.has_room  = (live_r < LOAD_MAX) && (CMPW'(live_r) < CMPW'(limit_r));
    sts.skip      = (drop_en_r && (slot_r == drop_slot_r)) || full;
    sts.any       = any_r;
    sts.drop_en   = drop_en_r;
    sts.div_busy  = div_busy;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

[src/ktbl_ctrl.sv]
// Controller: sequences lookup, debit, insert, room making, compaction and clear.
module ktbl_ctrl
  import ktbl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        room_done_r, room_done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST;
      room_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      room_done_r <= room_done_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    room_done_nxt = room_done_r;
    unique case (state_r)
      S_RST:     state_nxt = S_INIT;
      S_INIT:    if (sts.slot_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt     = S_DEC;
          room_done_nxt = 1'b0;
        end
      end
      S_DEC: begin
        if (sts.op_clear)      state_nxt = S_CLEAR;
        else if (sts.cost_bad) state_nxt = S_FIN;
        else                   state_nxt = S_LK_RD;
      end
      S_CLEAR:   if (sts.slot_last) state_nxt = S_FIN;
      S_LK_RD:   state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        if (!sts.rd_valid)   state_nxt = S_NF;
        else if (sts.rd_hit) state_nxt = S_F_MUL;
        else                 state_nxt = S_LK_RD;
      end
      S_F_MUL:   state_nxt = S_F_REF;
      S_F_REF:   state_nxt = S_F_DEBIT;
      S_F_DEBIT: state_nxt = sts.enough ? S_FIN : S_DIV;
      S_DIV:     if (!sts.div_busy) state_nxt = S_FIN;
      S_NF:      state_nxt = (room_done_r || sts.has_room) ? S_INS : S_SC_RD;
      S_INS:     state_nxt = S_FIN;
      S_SC_RD:   state_nxt = S_SC_CHK;
      S_SC_CHK:  state_nxt = sts.rd_valid ? S_SC_MUL : S_SC_NXT;
      S_SC_MUL:  state_nxt = S_SC_REF;
      S_SC_REF:  state_nxt = S_SC_UPD;
      S_SC_UPD:  state_nxt = S_SC_NXT;
      S_SC_NXT:  state_nxt = sts.slot_last ? S_SC_END : S_SC_RD;
      S_SC_END: begin
        if (sts.any) begin
          state_nxt = S_CN;
        end else begin
          state_nxt     = S_LK_RD;
          room_done_nxt = 1'b1;
        end
      end
      S_CN:      if (sts.np_last) state_nxt = S_CP_RD;
      S_CP_RD:   state_nxt = S_CP_CHK;
      S_CP_CHK:  state_nxt = sts.rd_valid ? S_CP_MUL : S_CP_NXT;
      S_CP_MUL:  state_nxt = S_CP_REF;
      S_CP_REF:  state_nxt = S_CP_EVAL;
      S_CP_EVAL: state_nxt = sts.skip ? S_CP_NXT : S_CP_PRD;
      S_CP_PRD:  state_nxt = S_CP_PCHK;
      S_CP_PCHK: state_nxt = sts.rd_valid ? S_CP_PRD : S_CP_NXT;
      S_CP_NXT:  state_nxt = sts.slot_last ? S_CP_FIN : S_CP_RD;
      S_CP_FIN: begin
        if (sts.drop_en) begin
          state_nxt     = S_RELOOK;
          room_done_nxt = 1'b1;
        end else begin
          state_nxt = S_ROOMCK;
        end
      end
      S_ROOMCK: begin
        if (sts.has_room) begin
          state_nxt     = S_RELOOK;
          room_done_nxt = 1'b1;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_RELOOK:  state_nxt = S_LK_RD;
      S_FIN:     if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_RST;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_RST: cmd.slot_clr = 1'b1;
      S_INIT, S_CLEAR: begin
        cmd.wr_kind  = WR_CLR_CUR;
        cmd.slot_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DEC: begin
        if (sts.op_clear) begin
          cmd.live_clr   = 1'b1;
          cmd.slot_clr   = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
        end else if (sts.cost_bad) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_INVALID;
        end else begin
          cmd.slot_ld_hash = 1'b1;
        end
      end
      S_LK_CHK: begin
        cmd.cap_row  = 1'b1;
        cmd.slot_inc = sts.rd_valid && !sts.rd_hit;
      end
      S_F_MUL, S_SC_MUL, S_CP_MUL: cmd.mul = 1'b1;
      S_F_REF, S_SC_REF, S_CP_REF: cmd.refill = 1'b1;
      S_F_DEBIT: begin
        cmd.wr_kind    = WR_ROW_CUR;
        cmd.res_set    = 1'b1;
        cmd.res_status = sts.enough ? ST_OK : ST_LIMITED;
        cmd.div_start  = !sts.enough;
      end
      S_NF: begin
        if (!(room_done_r || sts.has_room)) begin
          cmd.scan_clr = 1'b1;
          cmd.slot_clr = 1'b1;
        end
      end
      S_INS: begin
        cmd.wr_kind    = WR_INS;
        cmd.live_inc   = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = ST_OK;
      end
      S_SC_CHK, S_CP_CHK: cmd.cap_row = 1'b1;
      S_SC_UPD: cmd.scan_upd = 1'b1;
      S_SC_NXT, S_CP_NXT: cmd.slot_inc = 1'b1;
      S_SC_END: begin
        if (sts.any) begin
          cmd.set_drop = 1'b1;
          cmd.np_clr   = 1'b1;
          cmd.cnt_clr  = 1'b1;
        end else begin
          cmd.slot_ld_hash = 1'b1;
        end
      end
      S_CN: begin
        cmd.wr_kind = WR_CLR_NEW;
        cmd.np_inc  = 1'b1;
      end
      S_CP_EVAL: cmd.np_ld_hash = !sts.skip;
      S_CP_PRD: cmd.rd_new = 1'b1;
      S_CP_PCHK: begin
        cmd.rd_new = 1'b1;
        if (sts.rd_valid) begin
          cmd.np_inc = 1'b1;
        end else begin
          cmd.wr_kind = WR_ROW_NEW;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_CP_FIN: begin
        cmd.bank_flip   = 1'b1;
        cmd.live_ld_cnt = 1'b1;
      end
      S_ROOMCK: cmd.scan_clr = !sts.has_room;
      S_RELOOK: cmd.slot_ld_hash = 1'b1;
      S_FIN: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

[src/keyed_token_bucket_limiter_core.sv]
// Top level of the keyed token bucket limiter: controller, datapath and checks.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in_      | in_valid / in_ready     | in_data   (opcode, key, hash, time, cost)
//  out_     | out_valid / out_ready   | out_data  (status, retry_ticks, count)
//  cfg_     | cfg_we, no wait         | cfg_index, cfg_wdata
//
// One item at a time. Each probe of the table is a registered read: a read state, then a check state.
// A limited hit runs the bit-serial divider for its retry time.
// A new key with room is inserted directly. Clear walks every slot of the table.
// Making room scans the table slot by slot, clears the other bank and reinserts
// survivors into it; this may run twice.
// After reset a clearing pass over every slot runs with in_ready low.
// A stalled result waits in the output register; the next item is taken meanwhile.
module keyed_token_bucket_limiter_core
  import ktbl_pkg::*;
#(
  parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ktbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ktbl_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A result is loaded only into a free output register and then shows valid
  ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded over a pending one");

  ap_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid) else $error("loaded result not presented");

  // The divider is never restarted while busy, and no item enters while it runs
  ap_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");

  ap_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !sts.div_busy) else $error("transfer during division");

endmodule

[tb/tb_keyed_token_bucket_limiter_core.sv]
// Testbench for the keyed token bucket limiter: directed and random acquires and clears with a bucket-table predictor.
`timescale 1ns / 1ps

module tb_keyed_token_bucket_limiter_core;
  import ktbl_pkg::*;

  localparam int SLOTS        = DEFAULT_SLOTS;
  localparam int CYCLE_LIMIT  = 8000000;
  localparam logic [47:0] RETRY_SAT = 48'hFFFF_FFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BURST_CAP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  keyed_token_bucket_limiter_core #(.TABLE_SLOTS(SLOTS)) dut (.*);

  always #10 clk = ~clk;

  // Bucket table mirror and its register copies
  logic [31:0] m_cap, m_rate;
  logic [9:0]  m_limit;
  bit          b_used[SLOTS];
  logic [63:0] b_key[SLOTS];
  logic [31:0] b_hash[SLOTS], b_tok[SLOTS], b_last[SLOTS];
  int unsigned b_live;
  bit          n_used[SLOTS];
  logic [63:0] n_key[SLOTS];
  logic [31:0] n_hash[SLOTS], n_tok[SLOTS], n_last[SLOTS];

  out_item_t pending_results[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        cycles = 0;

  function automatic void refill_bucket(int i, logic [31:0] now);
    logic [63:0] sum;
    if (now <= b_last[i]) return;
    sum = {32'b0, b_tok[i]} + {32'b0, now - b_last[i]} * {32'b0, m_rate};
    b_tok[i] = (sum > {32'b0, m_cap}) ? m_cap : sum[31:0];
    b_last[i] = now;
  endfunction

  function automatic bit room_free();
    return ((b_live + 1) * 4 <= SLOTS * 3) && (b_live < m_limit);
  endfunction

  // Refill all buckets, then reinsert survivors in slot order
  function automatic void rebuild(logic [31:0] now, bit use_drop, int drop);
    int idx, count;
    count = 0;
    for (int i = 0; i < SLOTS; i++) n_used[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!b_used[i]) continue;
      refill_bucket(i, now);
      if ((use_drop && i == drop) || b_tok[i] >= m_cap) continue;
      idx = b_hash[i] % SLOTS;
      while (n_used[idx]) idx = (idx + 1) % SLOTS;
      n_used[idx] = 1;
      n_key[idx] = b_key[i];
      n_hash[idx] = b_hash[i];
      n_tok[idx] = b_tok[i];
      n_last[idx] = b_last[i];
      count++;
    end
    b_used = n_used;
    b_key = n_key;
    b_hash = n_hash;
    b_tok = n_tok;
    b_last = n_last;
    b_live = count;
  endfunction

  function automatic bit fullest_bucket(output int where);
    bit any;
    logic [31:0] best;
    any = 0;
    best = 0;
    where = 0;
    for (int i = 0; i < SLOTS; i++)
      if (b_used[i] && (!any || b_tok[i] > best)) begin
        best = b_tok[i];
        where = i;
        any = 1;
      end
    return any;
  endfunction

  function automatic void free_room(logic [31:0] now);
    int full_cnt, victim;
    full_cnt = 0;
    if (room_free()) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (!b_used[i]) continue;
      refill_bucket(i, now);
      if (b_tok[i] >= m_cap) full_cnt++;
    end
    if (full_cnt == 0) begin
      if (fullest_bucket(victim)) rebuild(now, 1, victim);
      return;
    end
    rebuild(now, 0, 0);
    if (room_free()) return;
    if (fullest_bucket(victim)) rebuild(now, 1, victim);
  endfunction

  function automatic int find_bucket(logic [63:0] key, logic [31:0] hash, output bit hit);
    int idx;
    idx = hash % SLOTS;
    hit = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!b_used[idx]) return idx;
      if (b_hash[idx] == hash && b_key[idx] == key) begin
        hit = 1;
        return idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    return idx;
  endfunction

  // Work out the verdict for one acquire or clear and update the mirror
  function automatic out_item_t police(in_item_t it);
    out_item_t   r;
    int          idx;
    bit          hit;
    logic [63:0] need, wait_ticks;
    r = '0;
    r.status = ST_OK;
    if (it.opcode == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) b_used[i] = 0;
      b_live = 0;
    end else if (it.cost == 0 || it.cost > m_cap) begin
      r.status = ST_INVALID;
    end else begin
      idx = find_bucket(it.flow_key, it.key_hash, hit);
      if (hit) begin
        refill_bucket(idx, it.timestamp);
        if (b_tok[idx] >= it.cost) begin
          b_tok[idx] = b_tok[idx] - it.cost;
        end else begin
          need = {32'b0, it.cost - b_tok[idx]} << 16;
          // A zero rate never refills: answer the longest wait
          wait_ticks = (m_rate == 0) ? {16'b0, RETRY_SAT} : need / {32'b0, m_rate};
          r.status = ST_LIMITED;
          r.retry_ticks = (wait_ticks > {16'b0, RETRY_SAT}) ? RETRY_SAT : wait_ticks[47:0];
        end
      end else begin
        free_room(it.timestamp);
        idx = find_bucket(it.flow_key, it.key_hash, hit);
        b_used[idx] = 1;
        b_key[idx] = it.flow_key;
        b_hash[idx] = it.key_hash;
        b_tok[idx] = m_cap - it.cost;
        b_last[idx] = it.timestamp;
        b_live++;
      end
    end
    r.tracked_count = b_live[9:0];
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.retry_ticks !== want.retry_ticks ||
            out_data.tracked_count !== want.tracked_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d retry=%0d cnt=%0d, got st=%0d retry=%0d cnt=%0d",
                     want.status, want.retry_ticks, want.tracked_count,
                     out_data.status, out_data.retry_ticks, out_data.tracked_count);
        end
      end
    end
  end

  // Receiver stalls in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item, hold it until the transfer, then maybe idle
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(police(it));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write one register, then drive the write enable low again
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BURST_CAP) m_cap = val;
    else if (idx == CFG_REFILL_RATE) m_rate = val;
    else if (idx == CFG_ENTRY_LIMIT) m_limit = val[9:0];
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic op, logic [63:0] key, logic [31:0] hash,
                                  logic [31:0] ts, logic [31:0] cost);
    in_item_t it;
    it.opcode = op;
    it.flow_key = key;
    it.key_hash = hash;
    it.timestamp = ts;
    it.cost = cost;
    return it;
  endfunction

  // Extremes, limiting, refill, time running backwards, key and hash aliasing, clear
  task automatic test_directed();
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd0, 32'd0));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd0, m_cap + 1));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd100, m_cap));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd100, 32'd1));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd99, 32'd70000));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd102, 32'd70000));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd5000, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd2, 32'd5, 32'd5000, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd1029, 32'd5000, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
    send_item(mk(OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, m_cap));
    send_item(mk(OP_ACQUIRE, 64'd0, 32'd0, 32'd0, 32'd1));
    send_item(mk(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd0, 32'hFFFF_FFFF));
    send_item(mk(OP_ACQUIRE, 64'd1, 32'd5, 32'd7, 32'd3));
    drain();
  endtask

  // Extreme register settings: huge bucket and rate, then the slowest rate and the smallest bucket
  task automatic test_reg_extremes();
    write_reg(CFG_BURST_CAP, 32'hFFFF_FFFF);
    write_reg(CFG_REFILL_RATE, 32'hFFFF_FFFF);
    send_item(mk(OP_ACQUIRE, 64'd9, 32'd40, 32'd10, 32'hFFFF_FFFF));
    send_item(mk(OP_ACQUIRE, 64'd9, 32'd40, 32'd10, 32'd5));
    send_item(mk(OP_ACQUIRE, 64'd9, 32'd40, 32'd11, 32'hFFFF_FFFF));
    drain();
    write_reg(CFG_REFILL_RATE, 32'd1);
    send_item(mk(OP_ACQUIRE, 64'd10, 32'd41, 32'd10, 32'hFFFF_FFFF));
    send_item(mk(OP_ACQUIRE, 64'd10, 32'd41, 32'd10, 32'hFFFF_FFFF));
    drain();
    write_reg(CFG_BURST_CAP, 32'd1);
    send_item(mk(OP_ACQUIRE, 64'd11, 32'd42, 32'd3, 32'd1));
    send_item(mk(OP_ACQUIRE, 64'd11, 32'd42, 32'd3, 32'd1));
    send_item(mk(OP_ACQUIRE, 64'd11, 32'd42, 32'd3, 32'd2));
    drain();
  endtask

  // Eviction of the fullest bucket, dropping full buckets, and a lowered limit
  task automatic test_eviction();
    write_reg(CFG_BURST_CAP, 32'd655360);
    write_reg(CFG_REFILL_RATE, 32'd65536);
    write_reg(CFG_ENTRY_LIMIT, 32'd3);
    send_item(mk(OP_CLEAR, 64'd0, 32'd0, 32'd0, 32'd0));
    send_item(mk(OP_ACQUIRE, 64'd20, 32'd7, 32'd100, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd21, 32'd7, 32'd100, 32'd131072));
    send_item(mk(OP_ACQUIRE, 64'd22, 32'd8, 32'd100, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd23, 32'd8, 32'd100, 32'd196608));
    send_item(mk(OP_ACQUIRE, 64'd24, 32'd7, 32'd101, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd25, 32'd9, 32'd200, 32'd65536));
    drain();
    write_reg(CFG_ENTRY_LIMIT, 32'd768);
    for (int k = 0; k < 5; k++)
      send_item(mk(OP_ACQUIRE, 64'd30 + k, 32'd3 + k, 32'd300, 32'd65536 * (k + 1)));
    drain();
    write_reg(CFG_ENTRY_LIMIT, 32'd2);
    send_item(mk(OP_ACQUIRE, 64'd40, 32'd3, 32'd300, 32'd65536));
    send_item(mk(OP_ACQUIRE, 64'd41, 32'd3, 32'd303, 32'd65536));
    drain();
  endtask

  // Random traffic over a small pool of flows with hash collisions
  logic [63:0] pool_key[16];
  logic [31:0] pool_hash[16];
  logic [31:0] now_tick = 0;

  task automatic test_random(int count, int clear_odds);
    in_item_t it;
    int       p;
    logic [31:0] c;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 15);
      it.opcode = ($urandom_range(0, clear_odds) == 0) ? OP_CLEAR : OP_ACQUIRE;
      if ($urandom_range(0, 9) == 0) begin
        it.flow_key = {$urandom, $urandom};
        it.key_hash = $urandom;
      end else begin
        it.flow_key = pool_key[p];
        it.key_hash = pool_hash[p];
      end
      case ($urandom_range(0, 9))
        0: now_tick = $urandom;
        1: now_tick = now_tick - $urandom_range(1, 5);
        default: now_tick = now_tick + $urandom_range(0, 3);
      endcase
      it.timestamp = now_tick;
      case ($urandom_range(0, 9))
        0: c = 32'd0;
        1: c = $urandom;
        2: c = m_cap;
        3, 4, 5: c = $urandom_range(m_cap / 2, m_cap);
        default: c = $urandom_range(1, m_cap / 4 + 1);
      endcase
      it.cost = c;
      send_item(it);
    end
    drain();
  endtask

  initial begin
    m_cap = CAP_RESET;
    m_rate = RATE_RESET;
    m_limit = LIMIT_RESET;
    b_live = 0;
    for (int i = 0; i < SLOTS; i++) b_used[i] = 0;
    for (int i = 0; i < 16; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = {16'($urandom_range(0, 65535)), 6'd0, 10'(i % 5)};
    end
    pool_key[1] = pool_key[0];
    pool_hash[2] = pool_hash[0];
    pool_hash[3] = pool_hash[0] ^ 32'h0001_0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_reg_extremes();
    test_eviction();

    write_reg(CFG_ENTRY_LIMIT, 32'd768);
    write_reg(CFG_BURST_CAP, 32'd655360);
    write_reg(CFG_REFILL_RATE, 32'd16384);
    test_random(350, 120);
    write_reg(CFG_BURST_CAP, 32'hFFFF_FFFF);
    write_reg(CFG_REFILL_RATE, 32'h0100_0000);
    test_random(250, 120);
    write_reg(CFG_BURST_CAP, 32'd300000);
    write_reg(CFG_REFILL_RATE, 32'd3000);
    write_reg(CFG_ENTRY_LIMIT, 32'd6);
    test_random(40, 200);
    write_reg(CFG_ENTRY_LIMIT, 32'd1);
    test_random(10, 200);
    write_reg(CFG_ENTRY_LIMIT, 32'd768);
    write_reg(CFG_BURST_CAP, 32'd1000000);
    write_reg(CFG_REFILL_RATE, 32'd65536);
    quiet = 1'b1;
    test_random(400, 150);

    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
